@@ src/sdrr_pkg.sv @@
// shared types, codes and reset values for the sd block read retry sequencer
`timescale 1ns / 1ps

package sdrr_pkg;

  localparam int unsigned ADDR_WIDTH_DEF = 32;

  // request kinds
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_CMD_RESP = 2'd1;
  localparam logic [1:0] REQ_STATE = 2'd2;
  localparam logic [1:0] REQ_DATA_DONE = 2'd3;

  // actions
  localparam logic [1:0] ACT_SEND = 2'd0;
  localparam logic [1:0] ACT_RESEND = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_FINISH = 2'd3;

  // error and status codes
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_CMD_CRC = 3'd1;
  localparam logic [2:0] ERR_NO_RESP = 3'd2;
  localparam logic [2:0] ERR_RESP_CRC = 3'd3;
  localparam logic [2:0] ERR_DATA_CRC = 3'd4;
  localparam logic [2:0] ERR_GENERAL = 3'd5;
  localparam logic [2:0] ERR_OTHER = 3'd6;
  localparam logic [2:0] ERR_UNUSED = 3'd7;

  // card states
  localparam logic [1:0] CST_TRANSFER = 2'd0;
  localparam logic [1:0] CST_SENDING = 2'd1;

  // configuration register indexes
  localparam logic [1:0] CFG_STD_CAP = 2'd0;
  localparam logic [1:0] CFG_BLOCK_SHIFT = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

  localparam logic RST_STD_CAP = 1'b0;
  localparam logic [3:0] RST_BLOCK_SHIFT = 4'd9;
  localparam logic [3:0] RST_RETRY_LIMIT = 4'd2;

  typedef struct packed {
    logic        standard_capacity;
    logic [3:0]  block_shift;
    logic [3:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic        active;
    logic        cmd_busy;
    logic        data_outstanding;
    logic [2:0]  held_data_error;
    logic [3:0]  cmd_tries_left;
    logic [3:0]  data_tries_left;
    logic [31:0] current_block;
    logic [31:0] target_count;
    logic [31:0] done_count;
  } seq_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] cmd_address;
    logic [31:0] blocks_done;
    logic [2:0]  status;
  } result_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] start_block;
    logic [31:0] block_total;
    logic [2:0]  error_code;
    logic [1:0]  card_state;
  } event_t;

endpackage

@@ src/sdrr_core.sv @@
// next-state and action logic for one event of the read sequencer
`timescale 1ns / 1ps

module sdrr_core #(
  parameter int unsigned ADDR_WIDTH = sdrr_pkg::ADDR_WIDTH_DEF
) (
  input  sdrr_pkg::cfg_t       cfg,
  input  sdrr_pkg::seq_state_t st,
  input  sdrr_pkg::event_t     ev,
  output sdrr_pkg::seq_state_t st_next,
  output logic                 emit,
  output sdrr_pkg::result_t    res
);

  localparam logic [31:0] AddrMask = 32'((33'd1 << ADDR_WIDTH) - 33'd1);

  logic [2:0]  err;
  logic        do_data;
  logic [2:0]  data_err;
  logic [31:0] done_inc;
  logic [46:0] byte_addr;
  logic [31:0] blk_addr;
  logic [1:0]  res_action;
  logic [2:0]  res_status;
  logic [31:0] cmd_addr;

  assign err = (ev.error_code == sdrr_pkg::ERR_UNUSED) ? sdrr_pkg::ERR_OTHER : ev.error_code;
  assign done_inc = st.done_count + 32'd1;

  always_comb begin
    st_next = st;
    emit = 1'b0;
    res_action = sdrr_pkg::ACT_SEND;
    res_status = sdrr_pkg::ERR_NONE;
    do_data = 1'b0;
    data_err = sdrr_pkg::ERR_NONE;

    case (ev.req_type)
      sdrr_pkg::REQ_START: begin
        st_next.active = 1'b1;
        st_next.held_data_error = sdrr_pkg::ERR_NONE;
        st_next.current_block = ev.start_block;
        st_next.target_count = ev.block_total;
        st_next.done_count = 32'd0;
        emit = 1'b1;
        if (ev.block_total != 32'd0) begin
          st_next.data_tries_left = cfg.retry_limit;
          st_next.cmd_tries_left = cfg.retry_limit;
          st_next.cmd_busy = 1'b1;
          st_next.data_outstanding = 1'b1;
          res_action = sdrr_pkg::ACT_SEND;
        end else begin
          st_next.active = 1'b0;
          st_next.cmd_busy = 1'b0;
          st_next.data_outstanding = 1'b0;
          res_action = sdrr_pkg::ACT_FINISH;
        end
      end
      sdrr_pkg::REQ_CMD_RESP, sdrr_pkg::REQ_STATE: begin
        if (st.active && st.cmd_busy) begin
          emit = 1'b1;
          if ((ev.req_type == sdrr_pkg::REQ_CMD_RESP && err == sdrr_pkg::ERR_NONE) ||
              (ev.req_type == sdrr_pkg::REQ_STATE && err == sdrr_pkg::ERR_NONE &&
               ev.card_state == sdrr_pkg::CST_SENDING)) begin
            // command complete
            emit = 1'b0;
            st_next.cmd_busy = 1'b0;
            if (!st.data_outstanding) begin
              do_data = 1'b1;
              data_err = st.held_data_error;
            end
          end else if ((ev.req_type == sdrr_pkg::REQ_CMD_RESP &&
                        (err == sdrr_pkg::ERR_CMD_CRC || err == sdrr_pkg::ERR_NO_RESP)) ||
                       (ev.req_type == sdrr_pkg::REQ_STATE && err == sdrr_pkg::ERR_NONE &&
                        ev.card_state == sdrr_pkg::CST_TRANSFER)) begin
            // command retry
            if (st.cmd_tries_left > 4'd1) begin
              st_next.cmd_tries_left = st.cmd_tries_left - 4'd1;
              res_action = sdrr_pkg::ACT_RESEND;
            end else begin
              st_next.cmd_tries_left = 4'd0;
              st_next.active = 1'b0;
              st_next.cmd_busy = 1'b0;
              st_next.data_outstanding = 1'b0;
              res_action = sdrr_pkg::ACT_FINISH;
              res_status = (ev.req_type == sdrr_pkg::REQ_STATE) ? sdrr_pkg::ERR_CMD_CRC : err;
            end
          end else if (ev.req_type == sdrr_pkg::REQ_CMD_RESP &&
                       err == sdrr_pkg::ERR_RESP_CRC) begin
            res_action = sdrr_pkg::ACT_QUERY;
          end else begin
            st_next.active = 1'b0;
            st_next.cmd_busy = 1'b0;
            st_next.data_outstanding = 1'b0;
            res_action = sdrr_pkg::ACT_FINISH;
            res_status = (err != sdrr_pkg::ERR_NONE) ? err : sdrr_pkg::ERR_GENERAL;
          end
        end
      end
      default: begin
        if (st.active && st.data_outstanding) begin
          st_next.data_outstanding = 1'b0;
          if (st.cmd_busy) begin
            st_next.held_data_error = err;
          end else begin
            do_data = 1'b1;
            data_err = err;
          end
        end
      end
    endcase

    // data transfer outcome
    if (do_data) begin
      emit = 1'b1;
      if (data_err == sdrr_pkg::ERR_NONE) begin
        st_next.done_count = done_inc;
        if (done_inc == st.target_count) begin
          st_next.active = 1'b0;
          st_next.cmd_busy = 1'b0;
          st_next.data_outstanding = 1'b0;
          res_action = sdrr_pkg::ACT_FINISH;
        end else begin
          st_next.current_block = st.current_block + 32'd1;
          st_next.data_tries_left = cfg.retry_limit;
          st_next.cmd_tries_left = cfg.retry_limit;
          st_next.data_outstanding = 1'b1;
          st_next.cmd_busy = 1'b1;
          st_next.held_data_error = sdrr_pkg::ERR_NONE;
          res_action = sdrr_pkg::ACT_SEND;
        end
      end else if (data_err == sdrr_pkg::ERR_DATA_CRC && st.data_tries_left > 4'd1) begin
        st_next.data_tries_left = st.data_tries_left - 4'd1;
        st_next.cmd_tries_left = cfg.retry_limit;
        st_next.data_outstanding = 1'b1;
        st_next.cmd_busy = 1'b1;
        st_next.held_data_error = sdrr_pkg::ERR_NONE;
        res_action = sdrr_pkg::ACT_SEND;
      end else begin
        if (data_err == sdrr_pkg::ERR_DATA_CRC) begin
          st_next.data_tries_left = 4'd0;
        end
        st_next.active = 1'b0;
        st_next.cmd_busy = 1'b0;
        st_next.data_outstanding = 1'b0;
        res_action = sdrr_pkg::ACT_FINISH;
        res_status = data_err;
      end
    end
  end

  assign byte_addr = {15'd0, st_next.current_block} << cfg.block_shift;
  assign blk_addr = (cfg.standard_capacity ? byte_addr[31:0] : st_next.current_block) & AddrMask;

  assign cmd_addr = (res_action == sdrr_pkg::ACT_SEND || res_action == sdrr_pkg::ACT_RESEND)
                    ? blk_addr : 32'd0;

  assign res = '{action: res_action, cmd_address: cmd_addr,
                 blocks_done: st_next.done_count, status: res_status};

endmodule

@@ src/sd_block_read_retry_sequencer_top.sv @@
// top level of the sd block read retry sequencer: registers and handshakes
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------------------
//   in       | in        | in_valid / in_ready  | req_type start_block block_total
//            |           |                      | error_code card_state
//   out      | out       | out_valid / out_ready| action cmd_address blocks_done status
//   cfg      | in        | cfg_valid / cfg_ready| cfg_index cfg_data
//
// one event per cycle while the output register is not stalled: an event is held in the
// input register, is decoded against the sequence state, and any action it emits lands
// in the output register
// the input register loads while empty or while the output register is empty or drained
// synchronous reset clears sequence state and valids and reloads the reset configuration
`timescale 1ns / 1ps

module sd_block_read_retry_sequencer_top #(
  parameter int unsigned ADDR_WIDTH = sdrr_pkg::ADDR_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] start_block,
  input  logic [31:0] block_total,
  input  logic [2:0]  error_code,
  input  logic [1:0]  card_state,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic [31:0] cmd_address,
  output logic [31:0] blocks_done,
  output logic [2:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  sdrr_pkg::cfg_t       cfg;
  sdrr_pkg::seq_state_t st;
  sdrr_pkg::seq_state_t st_next;
  sdrr_pkg::event_t     ev;
  sdrr_pkg::result_t    res;
  sdrr_pkg::result_t    out_reg;
  logic                 ev_valid;
  logic                 emit;
  logic                 fire;

  assign fire = ev_valid && (!out_valid || out_ready);
  assign in_ready = !ev_valid || fire;
  assign cfg_ready = 1'b1;

  sdrr_core #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_core (
    .cfg     (cfg),
    .st      (st),
    .ev      (ev),
    .st_next (st_next),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.standard_capacity <= sdrr_pkg::RST_STD_CAP;
      cfg.block_shift <= sdrr_pkg::RST_BLOCK_SHIFT;
      cfg.retry_limit <= sdrr_pkg::RST_RETRY_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        sdrr_pkg::CFG_STD_CAP:     cfg.standard_capacity <= cfg_data[0];
        sdrr_pkg::CFG_BLOCK_SHIFT: cfg.block_shift <= cfg_data;
        sdrr_pkg::CFG_RETRY_LIMIT: cfg.retry_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (in_ready) begin
      ev_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      ev.req_type <= req_type;
      ev.start_block <= start_block;
      ev.block_total <= block_total;
      ev.error_code <= error_code;
      ev.card_state <= card_state;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (fire && emit) begin
      out_reg <= res;
    end
  end

  assign action = out_reg.action;
  assign cmd_address = out_reg.cmd_address;
  assign blocks_done = out_reg.blocks_done;
  assign status = out_reg.status;

endmodule
